FILE: sv/ipt_pkg.sv
package ipt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = 32;
    localparam int LEN_W = 6;
    localparam int MAX_LEN = 32;
    localparam int ENTRY_W = ADDR_W + LEN_W;

    typedef enum logic [1:0] {
        OP_CHECK = 2'd0,
        OP_ADD   = 2'd1,
        OP_DEL   = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_BAD_LEN = 3'd1,
        STS_PRESENT = 3'd2,
        STS_FULL    = 3'd3,
        STS_NONE    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic early;
        logic scan_last;
        logic out_free;
    } t_stat;

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] mask;
        mask = '0;
        if (len != '0) begin
            mask = {ADDR_W{1'b1}} << (LEN_W'(MAX_LEN) - len);
        end
        return mask;
    endfunction

endpackage

FILE: sv/ipt_ctrl.sv
module ipt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ipt_pkg::t_stat i_stat,
    output ipt_pkg::t_cmd  o_cmd
);

    ipt_pkg::t_state r_state;
    ipt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ipt_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = i_stat.early ? ipt_pkg::S_DONE : ipt_pkg::S_SCAN;
                end
            end
            ipt_pkg::S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = ipt_pkg::S_DRAIN;
                end
            end
            ipt_pkg::S_DRAIN: begin
                n_state = ipt_pkg::S_DONE;
            end
            ipt_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ipt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ipt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready = (r_state == ipt_pkg::S_IDLE);
        o_cmd.latch = (r_state == ipt_pkg::S_IDLE) && i_valid;
        o_cmd.scan = (r_state == ipt_pkg::S_SCAN);
        o_cmd.finish = (r_state == ipt_pkg::S_DONE) && i_stat.out_free;
    end

endmodule

FILE: sv/ipt_dp.sv
module ipt_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_opcode,
    input  logic [ipt_pkg::ADDR_W-1:0]  i_address,
    input  logic [ipt_pkg::LEN_W-1:0]   i_prefix_len,
    input  ipt_pkg::t_cmd               i_cmd,
    output ipt_pkg::t_stat              o_stat,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic [2:0]                  o_status,
    output logic [ipt_pkg::LEN_W-1:0]   o_match_len
);

    logic [ipt_pkg::ENTRY_W-1:0] r_mem [ipt_pkg::TABLE_DEPTH];
    logic [ipt_pkg::TABLE_DEPTH-1:0] r_valid;
    logic [ipt_pkg::CNT_W-1:0] r_count;
    logic r_zero_present;

    ipt_pkg::t_opcode r_op;
    logic [ipt_pkg::ADDR_W-1:0] r_addr;
    logic [ipt_pkg::LEN_W-1:0] r_len;
    logic r_early;
    ipt_pkg::t_status r_early_sts;

    logic [ipt_pkg::IDX_W-1:0] r_scan_idx;
    logic r_rd_pend;
    logic r_rd_vld;
    logic [ipt_pkg::IDX_W-1:0] r_rd_idx;
    logic [ipt_pkg::ENTRY_W-1:0] r_rd_data;

    logic r_hit;
    logic [ipt_pkg::LEN_W-1:0] r_best;
    logic r_found;
    logic [ipt_pkg::IDX_W-1:0] r_found_idx;
    logic r_free_ok;
    logic [ipt_pkg::IDX_W-1:0] r_free_idx;

    logic r_out_valid;
    ipt_pkg::t_status r_out_sts;
    logic [ipt_pkg::LEN_W-1:0] r_out_len;

    ipt_pkg::t_opcode in_op;
    logic early;
    ipt_pkg::t_status early_sts;
    logic [ipt_pkg::ADDR_W-1:0] ent_addr;
    logic [ipt_pkg::LEN_W-1:0] ent_len;
    logic ent_live;
    logic ent_cover;
    logic ent_exact;
    ipt_pkg::t_status fin_sts;
    logic [ipt_pkg::LEN_W-1:0] fin_len;
    logic do_write;
    logic do_clear;
    logic out_free;

    // Requests that are settled without looking at the table.
    always_comb begin
        in_op = ipt_pkg::t_opcode'(i_opcode);
        early = 1'b0;
        early_sts = ipt_pkg::STS_NONE;
        priority if (in_op == ipt_pkg::OP_NOP) begin
            early = 1'b1;
            early_sts = ipt_pkg::STS_NONE;
        end else if (in_op != ipt_pkg::OP_CHECK
                     && i_prefix_len > ipt_pkg::LEN_W'(ipt_pkg::MAX_LEN)) begin
            early = 1'b1;
            early_sts = ipt_pkg::STS_BAD_LEN;
        end else if (in_op == ipt_pkg::OP_ADD && i_prefix_len == '0
                     && r_zero_present) begin
            early = 1'b1;
            early_sts = ipt_pkg::STS_PRESENT;
        end else begin
            early = 1'b0;
            early_sts = ipt_pkg::STS_NONE;
        end
    end

    always_comb begin
        ent_addr = r_rd_data[ipt_pkg::ENTRY_W-1:ipt_pkg::LEN_W];
        ent_len = r_rd_data[ipt_pkg::LEN_W-1:0];
        ent_live = r_rd_pend && r_rd_vld;
        ent_cover = (ent_len <= ipt_pkg::LEN_W'(ipt_pkg::MAX_LEN))
                    && (((ent_addr ^ r_addr) & ipt_pkg::prefix_mask(ent_len)) == '0);
        ent_exact = (ent_addr == r_addr) && (ent_len == r_len);
    end

    always_comb begin
        fin_sts = ipt_pkg::STS_NONE;
        fin_len = '0;
        do_write = 1'b0;
        do_clear = 1'b0;
        if (r_early) begin
            fin_sts = r_early_sts;
        end else begin
            unique case (r_op)
                ipt_pkg::OP_CHECK: begin
                    fin_sts = r_hit ? ipt_pkg::STS_OK : ipt_pkg::STS_NONE;
                    fin_len = r_hit ? r_best : '0;
                end
                ipt_pkg::OP_ADD: begin
                    priority if (r_found) begin
                        fin_sts = ipt_pkg::STS_PRESENT;
                    end else if (r_count == ipt_pkg::CNT_W'(ipt_pkg::TABLE_DEPTH)
                                 || !r_free_ok) begin
                        fin_sts = ipt_pkg::STS_FULL;
                    end else begin
                        fin_sts = ipt_pkg::STS_OK;
                        do_write = 1'b1;
                    end
                end
                ipt_pkg::OP_DEL: begin
                    fin_sts = r_found ? ipt_pkg::STS_OK : ipt_pkg::STS_NONE;
                    do_clear = r_found;
                end
                default: begin
                    fin_sts = ipt_pkg::STS_NONE;
                end
            endcase
        end
    end

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        o_stat.early = early;
        o_stat.scan_last = (r_scan_idx == ipt_pkg::IDX_W'(ipt_pkg::TABLE_DEPTH - 1));
        o_stat.out_free = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_data <= r_mem[r_scan_idx];
        end
        if (i_cmd.finish && do_write) begin
            r_mem[r_free_idx] <= {r_addr, r_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op <= in_op;
            r_addr <= i_address;
            r_len <= i_prefix_len;
            r_early_sts <= early_sts;
        end
        if (i_cmd.scan) begin
            r_rd_vld <= r_valid[r_scan_idx];
            r_rd_idx <= r_scan_idx;
        end
        if (i_cmd.finish) begin
            r_out_sts <= fin_sts;
            r_out_len <= fin_len;
        end
        if (i_cmd.latch) begin
            r_best <= '0;
        end else if (ent_live && ent_cover && (!r_hit || ent_len > r_best)) begin
            r_best <= ent_len;
        end
        if (ent_live && ent_exact && !r_found) begin
            r_found_idx <= r_rd_idx;
        end
        if (r_rd_pend && !r_rd_vld && !r_free_ok) begin
            r_free_idx <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_zero_present <= 1'b0;
            r_early <= 1'b0;
            r_scan_idx <= '0;
            r_rd_pend <= 1'b0;
            r_hit <= 1'b0;
            r_found <= 1'b0;
            r_free_ok <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.scan;
            if (i_cmd.latch) begin
                r_early <= early;
                r_scan_idx <= '0;
                r_hit <= 1'b0;
                r_found <= 1'b0;
                r_free_ok <= 1'b0;
            end else begin
                if (i_cmd.scan) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
                if (ent_live && ent_cover) begin
                    r_hit <= 1'b1;
                end
                if (ent_live && ent_exact) begin
                    r_found <= 1'b1;
                end
                if (r_rd_pend && !r_rd_vld) begin
                    r_free_ok <= 1'b1;
                end
            end
            if (i_cmd.finish && do_write) begin
                r_valid[r_free_idx] <= 1'b1;
                r_count <= r_count + 1'b1;
                if (r_len == '0) begin
                    r_zero_present <= 1'b1;
                end
            end else if (i_cmd.finish && do_clear) begin
                r_valid[r_found_idx] <= 1'b0;
                r_count <= r_count - 1'b1;
                if (r_len == '0) begin
                    r_zero_present <= 1'b0;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_status = r_out_sts;
    assign o_match_len = r_out_len;

endmodule

FILE: sv/ipv4_prefix_table_match.sv
// Every check, add or delete scans all TABLE_DEPTH slots through one memory read port,
// one slot per cycle, then passes a drain state and a done state; the result word is
// registered when the output is free, and only then is a new request word accepted.
// Requests rejected outright (bad length, repeated zero-length add, opcode 3) skip the scan.
// Reset empties the table and clears the output; the table memory itself is not cleared.
module ipv4_prefix_table_match (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_opcode,
    input  logic [ipt_pkg::ADDR_W-1:0]  i_address,
    input  logic [ipt_pkg::LEN_W-1:0]   i_prefix_len,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [2:0]                  o_status,
    output logic [ipt_pkg::LEN_W-1:0]   o_match_len
);

    ipt_pkg::t_cmd cmd;
    ipt_pkg::t_stat stat;

    ipt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ipt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_opcode     (i_opcode),
        .i_address    (i_address),
        .i_prefix_len (i_prefix_len),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_match_len  (o_match_len)
    );

endmodule
